>>> rtl/tosl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosl_pkg - shared types and constants of the speed and link watch
// Field widths, configuration register indexes, reset values and the link
// state codes used by the speed and link watch and its serial divider.
// ----------------------------------------------------------------------------
package tosl_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int POS_W    = 16;
    localparam int CONF_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int TMO_W    = 16;
    localparam int WEIGHT_W = 9;
    localparam int SPEED_W  = 32;
    localparam int COUNT_W  = 32;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 136;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_CONF_MIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT   = 2'd2;

    localparam logic [CONF_W-1:0]   CONF_MIN_RST = 8'd0;
    localparam logic [TMO_W-1:0]    TIMEOUT_RST  = 16'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 9'd77;

    // Blend: weight is out of 256, result rounded half away from zero
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 9'd256;
    localparam int                  BLEND_SHIFT = 8;
    localparam int                  SUM_W       = 42;

    typedef enum logic [1:0] {
        LINK_WAITING = 2'd0,
        LINK_READY   = 2'd1,
        LINK_INVALID = 2'd2,
        LINK_TIMEOUT = 2'd3
    } link_state_t;

endpackage

>>> rtl/tosl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosl_div - bit-serial restoring divider
// Divides an unsigned DIV_W-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. done pulses for one cycle when the quotient is complete.
// The divisor must hold steady until done.
// ----------------------------------------------------------------------------
module tosl_div #(
    parameter int DIV_W = 35
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DIV_W-1:0]           dividend,
    input  logic [tosl_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           quotient
);
    import tosl_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TIME_W:0]   trial;
    logic [TIME_W+1:0] diff;

    // One restoring step: bring in the next dividend bit, try to subtract
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = {1'b0, trial} - {2'b00, divisor};
        if (!diff[TIME_W+1]) begin
            rem_next = diff[TIME_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end else begin
            rem_next = trial[TIME_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    // Step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/tracked_object_speed_and_link_watch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracked_object_speed_and_link_watch - smoothed speed and camera link watch
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  one tick, optionally with a camera frame
//  m_*       out  m_tvalid/m_tready  link state, speed, counters, latest frame
//  cfg_*     in   cfg_we             confidence min, timeout, blend weight
//
// A tick without a frame, or a frame that gives no speed, passes the check,
// watchdog and emit steps; a frame that gives a speed also passes multiply,
// divide (one quotient bit per cycle), saturate, blend and round. The next
// tick waits for emit; a finished word waits in the output register and
// a stalled m_tready holds the block in its last step. Reset (aresetn,
// synchronous, active low) clears control, settings, tracker and m_tvalid.
// ----------------------------------------------------------------------------
module tracked_object_speed_and_link_watch #(
    parameter int SPEED_FRACTION_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms, frame_position_mm, frame_valid, frame_confidence,
    // frame_sequence, frame_receive_ms
    input  logic [tosl_pkg::IN_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // link_state, speed_q8, valid_frames, timeouts, have_frame,
    // latest_sequence, latest_position_mm
    output logic [tosl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [tosl_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [tosl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import tosl_pkg::*;

    // Numerator magnitude = |diff| * 1000 * 2^F, plus half the gap
    localparam int SCALE_W = 10 + SPEED_FRACTION_BITS;
    localparam int PROD_W  = POS_W + SCALE_W;
    localparam int DIV_W   = PROD_W + 1;
    localparam int QX_W    = (DIV_W > 33) ? DIV_W : 33;

    localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(1000 << SPEED_FRACTION_BITS);
    localparam logic [QX_W-1:0]    SAT_POS     = QX_W'(64'h7FFF_FFFF);
    localparam logic [QX_W-1:0]    SAT_NEG     = QX_W'(64'h8000_0000);
    localparam logic [SUM_W-1:0]   ROUND_HALF  = SUM_W'(1 << (BLEND_SHIFT - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_SAT,
        ST_BLEND1,
        ST_BLEND2,
        ST_ROUND1,
        ST_ROUND2,
        ST_WATCH,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [CONF_W-1:0]   conf_min_reg;
    logic [TMO_W-1:0]    timeout_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // Tracker state
    logic                       seen_reg;
    logic                       have_last_reg;
    logic signed [POS_W-1:0]    last_pos_reg;
    logic [TIME_W-1:0]          last_pos_time_reg;
    logic [TIME_W-1:0]          last_valid_reg;
    logic signed [SPEED_W-1:0]  smoothed_reg;
    logic [COUNT_W-1:0]         accepted_reg;
    logic [COUNT_W-1:0]         timeout_cnt_reg;
    link_state_t                link_reg;
    logic [SEQ_W-1:0]           last_seq_reg;

    // Latched input word
    logic                    mode_reg;
    logic [TIME_W-1:0]       now_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic                    fvalid_reg;
    logic [CONF_W-1:0]       conf_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [TIME_W-1:0]       recv_reg;

    // Working registers
    logic [TIME_W-1:0]         gap_reg;
    logic                      neg_reg;
    logic [POS_W-1:0]          mag_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [SPEED_W-1:0] raw_reg;
    logic signed [SUM_W-1:0]   p1_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]          rnd_reg;
    logic                      rneg_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // Combinational next values
    logic                      accepted;
    logic [TIME_W-1:0]         gap_next;
    logic [POS_W:0]            diff_next;
    logic [POS_W:0]            mag_next;
    logic [PROD_W-1:0]         prod_next;
    logic [DIV_W-1:0]          dividend;
    logic [DIV_W-1:0]          quotient;
    logic                      div_start;
    logic                      div_done;
    logic [QX_W-1:0]           q_ext;
    logic signed [SPEED_W-1:0] raw_next;
    logic [WEIGHT_W-1:0]       w_eff;
    logic [WEIGHT_W-1:0]       inv_w;
    logic signed [SUM_W-1:0]   p1_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          rnd_next;
    logic [SPEED_W-1:0]        smooth_q;
    logic signed [SPEED_W-1:0] smooth_next;
    logic [TIME_W-1:0]         age;
    logic                      expired;

    // Frame acceptance, gap and position change
    always_comb begin
        accepted  = fvalid_reg && (conf_reg >= conf_min_reg);
        gap_next  = recv_reg - last_pos_time_reg;
        diff_next = {pos_reg[POS_W-1], pos_reg} - {last_pos_reg[POS_W-1], last_pos_reg};
        mag_next  = diff_next[POS_W] ? ((POS_W+1)'(0) - diff_next) : diff_next;
    end

    // Numerator magnitude and rounded dividend
    assign prod_next = PROD_W'(mag_reg) * PROD_W'(SPEED_SCALE);
    assign dividend  = DIV_W'(prod_reg) + DIV_W'(gap_reg[TIME_W-1:1]);
    assign div_start = (state_reg == ST_DINIT);

    tosl_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (gap_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Raw speed: apply sign and saturate to 32 bits
    always_comb begin
        q_ext = QX_W'(quotient);
        if (!neg_reg) begin
            raw_next = (q_ext > SAT_POS) ? SPEED_W'(32'h7FFF_FFFF) : q_ext[SPEED_W-1:0];
        end else begin
            raw_next = (q_ext > SAT_NEG) ? SPEED_W'(32'h8000_0000)
                                         : SPEED_W'(0) - q_ext[SPEED_W-1:0];
        end
    end

    // Blend and round half away from zero
    always_comb begin
        w_eff       = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
        inv_w       = WEIGHT_ONE - w_eff;
        p1_next     = SUM_W'($signed({1'b0, inv_w})) * SUM_W'(smoothed_reg);
        sum_next    = p1_reg + SUM_W'($signed({1'b0, w_eff})) * SUM_W'(raw_reg);
        rnd_next    = sum_reg[SUM_W-1] ? (ROUND_HALF - $unsigned(sum_reg))
                                       : ($unsigned(sum_reg) + ROUND_HALF);
        smooth_q    = rnd_reg[BLEND_SHIFT +: SPEED_W];
        smooth_next = rneg_reg ? (SPEED_W'(0) - smooth_q) : smooth_q;
    end

    // Watchdog age, modulo 2^32
    assign age     = now_reg - last_valid_reg;
    assign expired = seen_reg && (age > TIME_W'(timeout_reg));

    // Control, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            conf_min_reg      <= CONF_MIN_RST;
            timeout_reg       <= TIMEOUT_RST;
            weight_reg        <= WEIGHT_RST;
            seen_reg          <= 1'b0;
            have_last_reg     <= 1'b0;
            last_pos_reg      <= '0;
            last_pos_time_reg <= '0;
            last_valid_reg    <= '0;
            smoothed_reg      <= '0;
            accepted_reg      <= '0;
            timeout_cnt_reg   <= '0;
            link_reg          <= LINK_WAITING;
            last_seq_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            // register writes
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CONF_MIN: conf_min_reg <= cfg_wdata[CONF_W-1:0];
                    CFG_TIMEOUT:  timeout_reg  <= cfg_wdata[TMO_W-1:0];
                    CFG_WEIGHT:   weight_reg   <= cfg_wdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // word taken; the emit step reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg   <= s_tuser;
                        now_reg    <= s_tdata[31:0];
                        pos_reg    <= s_tdata[47:32];
                        fvalid_reg <= s_tdata[48];
                        conf_reg   <= s_tdata[56:49];
                        seq_reg    <= s_tdata[72:57];
                        recv_reg   <= s_tdata[104:73];
                        state_reg  <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (mode_reg) begin
                        last_seq_reg <= seq_reg;
                        seen_reg     <= 1'b1;
                        if (accepted) begin
                            gap_reg           <= gap_next;
                            neg_reg           <= diff_next[POS_W];
                            mag_reg           <= mag_next[POS_W-1:0];
                            last_pos_reg      <= pos_reg;
                            last_pos_time_reg <= recv_reg;
                            have_last_reg     <= 1'b1;
                            accepted_reg      <= accepted_reg + 1'b1;
                            last_valid_reg    <= recv_reg;
                            link_reg          <= LINK_READY;
                            // speed only with an earlier position and a nonzero gap
                            if (have_last_reg && (gap_next != '0)) begin
                                state_reg <= ST_MUL;
                            end else begin
                                state_reg <= ST_WATCH;
                            end
                        end else begin
                            link_reg  <= LINK_INVALID;
                            state_reg <= ST_WATCH;
                        end
                    end else begin
                        state_reg <= ST_WATCH;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DINIT;
                end
                ST_DINIT: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    raw_reg   <= raw_next;
                    state_reg <= ST_BLEND1;
                end
                ST_BLEND1: begin
                    p1_reg    <= p1_next;
                    state_reg <= ST_BLEND2;
                end
                ST_BLEND2: begin
                    sum_reg   <= sum_next;
                    state_reg <= ST_ROUND1;
                end
                ST_ROUND1: begin
                    rnd_reg   <= rnd_next;
                    rneg_reg  <= sum_reg[SUM_W-1];
                    state_reg <= ST_ROUND2;
                end
                ST_ROUND2: begin
                    smoothed_reg <= smooth_next;
                    state_reg    <= ST_WATCH;
                end
                ST_WATCH: begin
                    // count each entry into timeout once
                    if (expired) begin
                        if (link_reg != LINK_TIMEOUT) begin
                            timeout_cnt_reg <= timeout_cnt_reg + 1'b1;
                        end
                        link_reg <= LINK_TIMEOUT;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= OUT_TDATA_W'({last_pos_reg, last_seq_reg, seen_reg,
                                                     timeout_cnt_reg, accepted_reg,
                                                     smoothed_reg, link_reg});
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the tracked object speed and link watch
// Streams update ticks, with or without camera frames, into the block. A
// scoreboard holds its own copy of the watch state and predicts each result
// word: link state, smoothed speed, counters and latest frame data. A short
// directed run covers saturation, rounding, time wrap and watchdog edges.
// Random runs follow under six register settings and three idle mixes.
// ----------------------------------------------------------------------------
module tb;
    import tosl_pkg::*;

    localparam int     FRAC_BITS   = 8;
    localparam longint SPEED_SCALE = 1000 * (64'sd1 << FRAC_BITS);
    localparam longint SPEED_MAX   = 64'sh7FFF_FFFF;
    localparam longint SPEED_MIN   = -SPEED_MAX - 1;
    localparam int     STALL_LIMIT = 4000;
    localparam int     SEG_ITEMS   = 140;

    // Input word, first field in the low bits
    typedef struct packed {
        logic [6:0]              pad;
        logic [TIME_W-1:0]       receive_ms;
        logic [SEQ_W-1:0]        seq_num;
        logic [CONF_W-1:0]       confidence;
        logic                    frame_ok;
        logic signed [POS_W-1:0] pos_mm;
        logic [TIME_W-1:0]       now_ms;
    } tick_word_t;

    // Result word, first field in the low bits
    typedef struct packed {
        logic [4:0]                pad;
        logic signed [POS_W-1:0]   last_pos_mm;
        logic [SEQ_W-1:0]          last_seq;
        logic                      have_frame;
        logic [COUNT_W-1:0]        timeouts;
        logic [COUNT_W-1:0]        valid_frames;
        logic signed [SPEED_W-1:0] speed_q8;
        link_state_t               link;
    } watch_result_t;

    // Tracks the watch state and the words it should produce
    class speed_link_scoreboard;
        logic [CONF_W-1:0]       conf_min;
        logic [TMO_W-1:0]        timeout_lim;
        logic [WEIGHT_W-1:0]     weight;
        bit                      seen_frame;
        bit                      have_pos;
        logic signed [POS_W-1:0] prev_pos;
        logic [TIME_W-1:0]       prev_pos_ms;
        logic [TIME_W-1:0]       last_good_ms;
        longint                  speed;
        logic [COUNT_W-1:0]      good_count;
        logic [COUNT_W-1:0]      tmo_count;
        link_state_t             link;
        logic [SEQ_W-1:0]        seq;
        watch_result_t           expected_q[$];
        int                      errors;
        int                      checked;
        int                      speed_updates;

        function new();
            conf_min      = CONF_MIN_RST;
            timeout_lim   = TIMEOUT_RST;
            weight        = WEIGHT_RST;
            seen_frame    = 1'b0;
            have_pos      = 1'b0;
            prev_pos      = '0;
            prev_pos_ms   = '0;
            last_good_ms  = '0;
            speed         = 0;
            good_count    = '0;
            tmo_count     = '0;
            link          = LINK_WAITING;
            seq           = '0;
            errors        = 0;
            checked       = 0;
            speed_updates = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_CONF_MIN: conf_min    = value[CONF_W-1:0];
                CFG_TIMEOUT:  timeout_lim = value[TMO_W-1:0];
                CFG_WEIGHT:   weight      = value[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // Quotient rounded to nearest, halves away from zero (den > 0)
        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One accepted tick: update state and queue the word it causes
        function void note_tick(logic mode, tick_word_t d);
            logic [TIME_W-1:0] gap;
            logic [TIME_W-1:0] age;
            int                diff;
            int                w;
            longint            raw;
            watch_result_t     r;
            if (mode) begin
                seq        = d.seq_num;
                seen_frame = 1'b1;
                if (d.frame_ok && d.confidence >= conf_min) begin
                    gap = d.receive_ms - prev_pos_ms;
                    if (have_pos && gap != 0) begin
                        w    = (weight > WEIGHT_ONE) ? int'(WEIGHT_ONE) : int'(weight);
                        diff = int'($signed(d.pos_mm)) - int'($signed(prev_pos));
                        raw  = round_div(longint'(diff) * SPEED_SCALE, longint'(gap));
                        if (raw > SPEED_MAX)
                            raw = SPEED_MAX;
                        else if (raw < SPEED_MIN)
                            raw = SPEED_MIN;
                        speed = round_div(longint'(int'(WEIGHT_ONE) - w) * speed
                                          + longint'(w) * raw, longint'(WEIGHT_ONE));
                        speed_updates++;
                    end
                    prev_pos     = d.pos_mm;
                    prev_pos_ms  = d.receive_ms;
                    have_pos     = 1'b1;
                    good_count   = good_count + 1'b1;
                    last_good_ms = d.receive_ms;
                    link         = LINK_READY;
                end else begin
                    link = LINK_INVALID;
                end
            end
            // watchdog age wraps with the millisecond counter
            age = d.now_ms - last_good_ms;
            if (seen_frame && age > timeout_lim) begin
                if (link != LINK_TIMEOUT)
                    tmo_count = tmo_count + 1'b1;
                link = LINK_TIMEOUT;
            end
            r.pad          = '0;
            r.link         = link;
            r.speed_q8     = speed[SPEED_W-1:0];
            r.valid_frames = good_count;
            r.timeouts     = tmo_count;
            r.have_frame   = seen_frame;
            r.last_seq     = seq;
            r.last_pos_mm  = prev_pos;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // One accepted result word against the oldest prediction
        function void check_result(watch_result_t got);
            watch_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with nothing expected: expected none actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                checked++;
                check_field("link_state", want.link, got.link);
                check_field("speed_q8", want.speed_q8, got.speed_q8);
                check_field("valid_frames", want.valid_frames, got.valid_frames);
                check_field("timeouts", want.timeouts, got.timeouts);
                check_field("have_frame", want.have_frame, got.have_frame);
                check_field("latest_sequence", want.last_seq, got.last_seq);
                check_field("latest_position_mm", want.last_pos_mm, got.last_pos_mm);
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    speed_link_scoreboard sb = new();

    int                      src_idle_pct  = 0;
    int                      sink_idle_pct = 0;
    int                      idle_cycles   = 0;
    int                      ticks_sent    = 0;
    logic [TIME_W-1:0]       t_now         = '0;
    logic [TIME_W-1:0]       t_recv        = '0;
    logic signed [POS_W-1:0] t_pos         = '0;
    logic [SEQ_W-1:0]        t_seq         = '0;

    tracked_object_speed_and_link_watch #(
        .SPEED_FRACTION_BITS(FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: ends the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog: no word moved in %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.pending());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic tick_word_t pack_tick(logic [TIME_W-1:0] now, logic [POS_W-1:0] pos,
                                             logic ok, logic [CONF_W-1:0] conf,
                                             logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] recv);
        tick_word_t d;
        d.pad        = '0;
        d.now_ms     = now;
        d.pos_mm     = pos;
        d.frame_ok   = ok;
        d.confidence = conf;
        d.seq_num    = seq;
        d.receive_ms = recv;
        return d;
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept
    task automatic send_word(input logic mode, input tick_word_t d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= d;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_tick(mode, d);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender off until every predicted word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(index, value);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] conf,
                             input logic [CFG_DATA_W-1:0] tmo,
                             input logic [CFG_DATA_W-1:0] w);
        write_reg(CFG_CONF_MIN, conf);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_WEIGHT, w);
    endtask

    // Mostly a camera stream moving in time; some bare ticks and some noise
    task automatic make_item(output logic mode, output tick_word_t d);
        int pick;
        int step;
        pick         = $urandom_range(99);
        d.pad        = '0;
        d.now_ms     = $urandom();
        d.pos_mm     = 16'($urandom());
        d.frame_ok   = 1'($urandom());
        d.confidence = 8'($urandom());
        d.seq_num    = 16'($urandom());
        d.receive_ms = $urandom();
        if (pick < 8) begin
            mode = 1'($urandom_range(1));
        end else if (pick < 22) begin
            // bare tick: small steps, watchdog edge or a long silence
            mode = 1'b0;
            case ($urandom_range(3))
                0:       t_now = t_now + $urandom_range(20);
                1:       t_now = sb.last_good_ms + sb.timeout_lim + $urandom_range(1);
                2:       t_now = t_now + $urandom_range(70000);
                default: t_now = t_now + $urandom_range(150);
            endcase
            d.now_ms = t_now;
        end else begin
            mode  = 1'b1;
            step  = int'($urandom_range(1000)) - 500;
            t_now = t_now + $urandom_range(40);
            // sometimes reuse the receive time for a zero gap
            if ($urandom_range(7) != 0)
                t_recv = t_now - $urandom_range(5);
            if ($urandom_range(19) == 0)
                t_pos = 16'($urandom());
            else
                t_pos = t_pos + 16'(step);
            t_seq        = t_seq + 1'b1;
            d.now_ms     = t_now;
            d.receive_ms = t_recv;
            d.pos_mm     = t_pos;
            d.seq_num    = t_seq;
            d.frame_ok   = ($urandom_range(9) != 0);
        end
    endtask

    initial begin
        logic       mode;
        tick_word_t d;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, then a stricter confidence floor
        send_word(1'b0, pack_tick(32'd0, 16'h0000, 1'b0, 8'h00, 16'h0000, 32'd0));
        send_word(1'b0, pack_tick(32'hFFFF_FFFF, 16'h7FFF, 1'b1, 8'hFF, 16'hFFFF,
                                  32'hFFFF_FFFF));
        send_word(1'b1, pack_tick(32'd10, 16'd500, 1'b0, 8'hFF, 16'hFFFF, 32'd10));
        send_word(1'b0, pack_tick(32'd100, 16'h0000, 1'b0, 8'h00, 16'h0000, 32'd0));
        send_word(1'b0, pack_tick(32'd101, 16'h0000, 1'b0, 8'h00, 16'h0000, 32'd0));
        send_word(1'b0, pack_tick(32'd300, 16'h0000, 1'b0, 8'h00, 16'h0000, 32'd0));
        // first accepted position, then saturating raw speeds
        send_word(1'b1, pack_tick(32'd300, 16'h0000, 1'b1, 8'h00, 16'h0000, 32'd300));
        send_word(1'b1, pack_tick(32'd301, 16'h7FFF, 1'b1, 8'hFF, 16'h0001, 32'd301));
        send_word(1'b1, pack_tick(32'd302, 16'h8000, 1'b1, 8'hC8, 16'h0002, 32'd302));
        // zero receive gap keeps the speed
        send_word(1'b1, pack_tick(32'd302, 16'd100, 1'b1, 8'hC8, 16'h0003, 32'd302));
        // receive time wrapping through zero
        send_word(1'b1, pack_tick(32'hFFFF_FFF0, 16'h0000, 1'b1, 8'h80, 16'h0004,
                                  32'hFFFF_FFF0));
        send_word(1'b1, pack_tick(32'h10, 16'd8, 1'b1, 8'h80, 16'h0005, 32'h10));
        send_word(1'b0, pack_tick(32'h10 + 32'd100, 16'h0000, 1'b0, 8'h00, 16'h0000, 32'd0));
        // stale frame: ready, then timed out in the same tick
        send_word(1'b1, pack_tick(32'd1000, 16'd3, 1'b1, 8'h80, 16'h0006, 32'd500));
        // half-step raw speeds round away from zero
        send_word(1'b1, pack_tick(32'd2000, 16'd0, 1'b1, 8'h80, 16'h0007, 32'd2000));
        send_word(1'b1, pack_tick(32'd514000, 16'd1, 1'b1, 8'h80, 16'h0008, 32'd514000));
        send_word(1'b1, pack_tick(32'd1026000, 16'd0, 1'b1, 8'h80, 16'h0009, 32'd1026000));
        drain_results();
        write_reg(CFG_CONF_MIN, 16'd100);
        // just under and at the confidence floor
        send_word(1'b1, pack_tick(32'd1026001, 16'd40, 1'b1, 8'd99, 16'h000A, 32'd1026001));
        send_word(1'b1, pack_tick(32'd1026001, 16'd50, 1'b1, 8'd100, 16'h000B, 32'd1026001));
        send_word(1'b0, pack_tick(32'd1026102, 16'h5A5A, 1'b1, 8'hA5, 16'h1234, 32'd7));
        // invalid frame while timed out counts a fresh entry
        send_word(1'b1, pack_tick(32'd1026102, 16'd5, 1'b0, 8'hFF, 16'hFFFF, 32'd1026102));

        // Random runs: sender-light, receiver-light, then no idling
        for (int seg = 0; seg < 6; seg++) begin
            src_idle_pct  = (seg < 2) ? 13 : (seg < 4) ? 52 : 0;
            sink_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 13 : 0;
            drain_results();
            case (seg)
                0: write_all(16'd128, 16'd50, 16'd0);
                1: write_all(16'd0, 16'hFFFF, 16'd511);
                2: write_all(16'd255, 16'd0, 16'd256);
                3: write_all(16'($urandom_range(255)), 16'($urandom()),
                             16'($urandom_range(511)));
                4: write_all(16'($urandom_range(255)), 16'($urandom_range(300)),
                             16'($urandom_range(256)));
                default: write_all(16'(CONF_MIN_RST), 16'(TIMEOUT_RST), 16'(WEIGHT_RST));
            endcase
            // odd runs start just before the millisecond counter wraps
            t_now  = (seg % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom();
            t_recv = t_now;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(99) == 0)
                    drain_results();
                make_item(mode, d);
                send_word(mode, d);
            end
        end

        drain_results();
        repeat (60) @(negedge aclk);
        $display("run: %0d ticks, %0d result words checked, %0d frames accepted,",
                 ticks_sent, sb.checked, sb.good_count);
        $display("run: %0d speed blends and %0d timeout entries over six register settings",
                 sb.speed_updates, sb.tmo_count);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tosl_pkg.sv
rtl/tosl_div.sv
rtl/tracked_object_speed_and_link_watch.sv
tb/sv/tb.sv
